// File: hw/rtl/qcir_pkg.sv
// Package for the quadrature counter with index and rpm measurement.
// Holds the opcode and register codes, the result word type and the rpm
// constants. No dependencies.
`timescale 1ns / 1ps

package qcir_pkg;

   // Input opcodes
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_LOAD   = 1'b1
   } opcode_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PLAIN_MODE      = 1'b0,
      CSR_PRESET_POSITION = 1'b1
   } csr_index_type;

   // Field widths
   localparam int unsigned POS_W  = 32;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned RPM_W  = 26;

   // Reset values
   localparam logic signed [POS_W-1:0] COUNT_RESET = 32'sd40000;

   // 60 s expressed in microseconds, dividend of the rpm calculation
   localparam logic [RPM_W-1:0]  RPM_NUMERATOR   = 26'd60000000;
   localparam logic [TIME_W-1:0] RPM_NUMERATOR_T = 32'd60000000;

   // Restoring divider: one quotient bit per cycle
   localparam int unsigned DIV_STEPS = RPM_W;
   localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   // Result word
   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic [RPM_W-1:0]        speed_rpm;
      logic                    index_event;
   } rsp_word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;    // an input word is taken this cycle
      logic div_step;  // one divider iteration
      logic div_done;  // divider finished, commit rpm
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic needs_div; // the offered word is an index edge needing division
   } dp_status_type;

endpackage

// File: hw/rtl/qcir_ifs.sv
// Valid/ready channel interfaces for encoder sample words and result words.
// Depends on qcir_pkg for field widths.
`timescale 1ns / 1ps

interface qcir_req_if;
   logic                           valid;
   logic                           ready;
   logic                           opcode;
   logic                           a_level;
   logic                           b_level;
   logic                           z_level;
   logic [qcir_pkg::TIME_W-1:0]    time_us;

   modport source (output valid, opcode, a_level, b_level, z_level, time_us,
                   input ready);
   modport sink   (input valid, opcode, a_level, b_level, z_level, time_us,
                   output ready);
   modport monitor (input valid, ready, opcode, a_level, b_level, z_level,
                    time_us);
endinterface

interface qcir_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [qcir_pkg::POS_W-1:0]  position;
   logic [qcir_pkg::RPM_W-1:0]         speed_rpm;
   logic                               index_event;

   modport source (output valid, position, speed_rpm, index_event,
                   input ready);
   modport sink   (input valid, position, speed_rpm, index_event,
                   output ready);
   modport monitor (input valid, ready, position, speed_rpm, index_event);
endinterface

// File: hw/rtl/qcir_ctrl.sv
// Controller FSM: input handshake, divider sequencing and result push.
// Depends on qcir_pkg.
`timescale 1ns / 1ps

module qcir_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  qcir_pkg::dp_status_type status,
   input  logic                    buf_full,
   output qcir_pkg::dp_cmd_type    cmd,
   output logic                    push
);
   import qcir_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;

   // Take a word only while idle and the result buffer has a free slot
   assign req_ready = (state_ff == ST_IDLE) && !buf_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.accept   = 1'b0;
      cmd.div_step = 1'b0;
      cmd.div_done = 1'b0;
      push         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = accept;
            if (accept) begin
               if (status.needs_div) begin
                  state_in = ST_DIV;
                  step_in  = '0;
               end else begin
                  push = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.div_done = 1'b1;
            push         = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: hw/rtl/qcir_datapath.sv
// Datapath: configuration registers, edge decode, position counter, index
// timing and the restoring rpm divider. Depends on qcir_pkg.
`timescale 1ns / 1ps

module qcir_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [qcir_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qcir_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                          opcode,
   input  logic                          a_level,
   input  logic                          b_level,
   input  logic                          z_level,
   input  logic [qcir_pkg::TIME_W-1:0]   time_us,
   input  qcir_pkg::dp_cmd_type          cmd,
   output qcir_pkg::dp_status_type       status,
   output qcir_pkg::rsp_word_type        rsp_word
);
   import qcir_pkg::*;

   logic                    plain_ff;
   logic signed [POS_W-1:0] preset_ff;
   logic signed [POS_W-1:0] count_ff, count_in;
   logic                    a_prev_ff, b_prev_ff, z_prev_ff;
   logic [TIME_W-1:0]       last_time_ff;
   logic [RPM_W-1:0]        rpm_ff, rpm_in;

   logic [RPM_W-1:0]        divisor_ff;
   logic [RPM_W-1:0]        rem_ff, rem_in;
   logic [RPM_W-1:0]        quo_ff, quo_in;
   logic [RPM_W:0]          rem_shift;
   logic                    rem_ge;

   logic                    is_load;
   logic                    z_rise;
   logic [TIME_W-1:0]       interval;
   logic                    long_interval, zero_interval;
   logic                    a_mid;
   logic signed [2:0]       step_a, step_b, delta;
   logic                    up_plain, dn_plain;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         plain_ff  <= 1'b0;
         preset_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PLAIN_MODE:      plain_ff  <= csr_wr_data[0];
            CSR_PRESET_POSITION: preset_ff <= signed'(csr_wr_data[POS_W-1:0]);
            default: ;
         endcase
      end
   end

   assign is_load = (opcode_type'(opcode) == OP_LOAD);

   // Quadrature decode: A first, then B against the updated A level
   always_comb begin
      step_a = 3'sd0;
      step_b = 3'sd0;
      a_mid  = a_prev_ff;
      if (a_level != a_prev_ff) begin
         step_a = (a_prev_ff == b_prev_ff) ? 3'sd1 : -3'sd1;
         a_mid  = a_level;
      end
      if (b_level != b_prev_ff) begin
         step_b = (a_mid != b_prev_ff) ? 3'sd1 : -3'sd1;
      end
      // plain mode: single rising edges with the other channel low
      up_plain = a_level && !a_prev_ff && !b_level;
      dn_plain = b_level && !b_prev_ff && !a_level;
      if (plain_ff) begin
         delta = (up_plain ? 3'sd1 : 3'sd0) - (dn_plain ? 3'sd1 : 3'sd0);
      end else begin
         delta = step_a + step_b;
      end
   end

   // Index edge and interval classification
   assign z_rise        = z_level && !z_prev_ff && !is_load;
   assign interval      = time_us - last_time_ff;
   assign long_interval = (interval >= RPM_NUMERATOR_T);
   assign zero_interval = (interval == '0);
   assign status.needs_div = z_rise && !long_interval && !zero_interval;

   // Next count for every word, and rpm for a word that finishes without the divider
   always_comb begin
      rpm_in = rpm_ff;
      if (is_load) begin
         count_in = preset_ff;
      end else if (z_rise) begin
         count_in = '0;
         if (zero_interval) begin
            rpm_in = RPM_NUMERATOR;
         end else begin
            rpm_in = '0;
         end
      end else begin
         count_in = count_ff + {{(POS_W-3){delta[2]}}, delta};
      end
   end

   // Pin state, count, index time and rpm
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         a_prev_ff    <= 1'b0;
         b_prev_ff    <= 1'b0;
         z_prev_ff    <= 1'b0;
         last_time_ff <= '0;
         rpm_ff       <= '0;
      end else if (cmd.accept) begin
         count_ff <= count_in;
         if (!is_load) begin
            a_prev_ff <= a_level;
            b_prev_ff <= b_level;
            z_prev_ff <= z_level;
            if (z_rise) begin
               last_time_ff <= time_us;
            end
            if (!status.needs_div) begin
               rpm_ff <= rpm_in;
            end
         end
      end else if (cmd.div_done) begin
         rpm_ff <= quo_ff;
      end
   end

   // Restoring divider: dividend bits shift out of quo_ff as quotient bits enter
   assign rem_shift = {rem_ff, quo_ff[RPM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, divisor_ff});

   always_comb begin
      if (rem_ge) begin
         rem_in = RPM_W'(rem_shift - {1'b0, divisor_ff});
      end else begin
         rem_in = rem_shift[RPM_W-1:0];
      end
      quo_in = {quo_ff[RPM_W-2:0], rem_ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && status.needs_div) begin
         divisor_ff <= interval[RPM_W-1:0];
         rem_ff     <= '0;
         quo_ff     <= RPM_NUMERATOR;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Result word toward the output buffer
   always_comb begin
      if (cmd.div_done) begin
         rsp_word.position    = '0;
         rsp_word.speed_rpm   = quo_ff;
         rsp_word.index_event = 1'b1;
      end else begin
         rsp_word.position    = count_in;
         rsp_word.speed_rpm   = rpm_in;
         rsp_word.index_event = z_rise;
      end
   end

endmodule

// File: hw/rtl/qcir_rsp_buf.sv
// Two-entry output buffer that drives the result channel.
// Depends on qcir_pkg and qcir_rsp_if.
`timescale 1ns / 1ps

module qcir_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  qcir_pkg::rsp_word_type push_word,
   output logic                   full,
   qcir_rsp_if.source             rsp_port
);
   import qcir_pkg::*;

   rsp_word_type head_ff, head_in, tail_ff, tail_in;
   logic         head_vld_ff, head_vld_in, tail_vld_ff, tail_vld_in;
   logic         pop;

   assign pop  = head_vld_ff && rsp_port.ready;
   assign full = tail_vld_ff;

   // Pop shifts the tail forward, push fills the first free slot
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      head_vld_in = head_vld_ff;
      tail_vld_in = tail_vld_ff;
      if (pop) begin
         head_in     = tail_ff;
         head_vld_in = tail_vld_ff;
         tail_vld_in = 1'b0;
      end
      if (push) begin
         if (!head_vld_in) begin
            head_in     = push_word;
            head_vld_in = 1'b1;
         end else begin
            tail_in     = push_word;
            tail_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         tail_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         tail_vld_ff <= tail_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_port.valid       = head_vld_ff;
   assign rsp_port.position    = head_ff.position;
   assign rsp_port.speed_rpm   = head_ff.speed_rpm;
   assign rsp_port.index_event = head_ff.index_event;

endmodule

// File: hw/rtl/quadrature_counter_index_rpm_unit.sv
// Quadrature encoder counter with index pulse and rpm measurement.
//
// req_port carries one word per encoder sample (A, B, Z levels and a
// microsecond timestamp) or a load command that presets the position.
// rsp_port returns exactly one word per request: position after the word,
// the last rpm value and an index flag. csr_* writes plain_mode (index 0)
// and preset_position (index 1), one register per cycle, no read-back.
//
// Loads and samples with no division enter the output buffer when accepted.
// A sample that sees a Z rise with an interval between 1 and 59999999 us
// runs the restoring divider, one quotient bit per cycle, and its result
// is pushed after the last step and the next word waits for that push.
// Other words sustain one per cycle while the output buffer has room.
//
// Reset (synchronous, active high) returns the count to 40000, clears the
// pin history, index time and rpm, and empties the output buffer.
// A two-entry output buffer lets one word be accepted while a result
// waits; with both entries held by a stalled receiver, req_port.ready drops.
// Depends on qcir_pkg, qcir_ifs, qcir_ctrl, qcir_datapath, qcir_rsp_buf.
`timescale 1ns / 1ps

module quadrature_counter_index_rpm_unit (
   input  logic                                clock,
   input  logic                                reset,
   qcir_req_if.sink                            req_port,
   qcir_rsp_if.source                          rsp_port,
   input  logic                                csr_wr_en,
   input  logic [qcir_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qcir_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import qcir_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   rsp_word_type  rsp_word;
   logic          push;
   logic          buf_full;

   qcir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .buf_full  (buf_full),
      .cmd       (cmd),
      .push      (push)
   );

   qcir_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .opcode      (req_port.opcode),
      .a_level     (req_port.a_level),
      .b_level     (req_port.b_level),
      .z_level     (req_port.z_level),
      .time_us     (req_port.time_us),
      .cmd         (cmd),
      .status      (status),
      .rsp_word    (rsp_word)
   );

   qcir_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (rsp_word),
      .full      (buf_full),
      .rsp_port  (rsp_port)
   );

endmodule

// File: hw/rtl/qcir_checker.sv
// Port-level checks for the encoder counter unit, bound to the top level.
// Depends on qcir_pkg.
`timescale 1ns / 1ps

module qcir_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [qcir_pkg::POS_W-1:0] rsp_position,
   input logic [qcir_pkg::RPM_W-1:0]        rsp_speed_rpm,
   input logic                              rsp_index_event
);
   import qcir_pkg::*;

   // Output buffer is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An index word always reports a cleared position
   a_index_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_event) |-> (rsp_position == '0))
      else $error("index result with nonzero position");

   // rpm never exceeds the saturation value
   a_rpm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed_rpm <= RPM_NUMERATOR))
      else $error("rpm above saturation");

   // A stalled result holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_position) &&
          $stable(rsp_speed_rpm) && $stable(rsp_index_event)))
      else $error("stalled result changed");

endmodule

bind quadrature_counter_index_rpm_unit qcir_checker u_qcir_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_position    (rsp_port.position),
   .rsp_speed_rpm   (rsp_port.speed_rpm),
   .rsp_index_event (rsp_port.index_event)
);

// File: sim/quadrature_counter_index_rpm_unit_tb.sv
// Testbench for quadrature_counter_index_rpm_unit: directed and random encoder
// traffic, checked word by word against an in-bench model of the counter.
// Depends on qcir_pkg, qcir_ifs and the unit's RTL.
`timescale 1ns / 1ps

module quadrature_counter_index_rpm_unit_tb;
   import qcir_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned IDLE_PCT     = 35;
   localparam int unsigned PRINT_LIMIT  = 40;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   qcir_req_if req_bus ();
   qcir_rsp_if rsp_bus ();

   quadrature_counter_index_rpm_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Model of the counter: configuration copy and encoder state
   logic                    plain_reg   = 1'b0;
   logic signed [POS_W-1:0] preset_reg  = COUNT_RESET;
   logic signed [POS_W-1:0] enc_count   = COUNT_RESET;
   logic                    a_seen      = 1'b0;
   logic                    b_seen      = 1'b0;
   logic                    z_seen      = 1'b0;
   logic [TIME_W-1:0]       index_stamp = '0;
   logic [RPM_W-1:0]        rpm_hold    = '0;

   rsp_word_type pending_rsp[$];

   bit sender_gaps     = 1'b1;
   bit receiver_stalls = 1'b1;

   int unsigned error_count     = 0;
   int unsigned words_accepted  = 0;
   int unsigned results_checked = 0;
   int unsigned index_edges     = 0;
   int unsigned loads_taken     = 0;
   int unsigned cycle_count     = 0;

   // Clock
   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_rsp.size());
      $display("quadrature_counter_index_rpm_unit test failed");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("MISMATCH %s", msg);
   endtask

   // Advance the encoder model by one word and return the result it gives
   function automatic rsp_word_type advance_encoder(input opcode_type op, input logic a,
                                                    input logic b, input logic z,
                                                    input logic [TIME_W-1:0] t);
      rsp_word_type w;
      logic [TIME_W-1:0] span;
      w.index_event = 1'b0;
      if (op == OP_LOAD) begin
         enc_count = preset_reg;
      end else begin
         if (!plain_reg) begin
            // every edge counts; A first, then B against the new A level
            if (a != a_seen) begin
               enc_count += (a_seen == b_seen) ? 1 : -1;
               a_seen = a;
            end
            if (b != b_seen) begin
               enc_count += (a_seen != b_seen) ? 1 : -1;
               b_seen = b;
            end
         end else begin
            if (a && !a_seen && !b) enc_count += 1;
            if (b && !b_seen && !a) enc_count -= 1;
            a_seen = a;
            b_seen = b;
         end
         // index rise clears the count and measures the period
         if (z && !z_seen) begin
            span = t - index_stamp;
            w.index_event = 1'b1;
            enc_count = '0;
            if (span >= RPM_NUMERATOR_T) rpm_hold = '0;
            else if (span == '0) rpm_hold = RPM_NUMERATOR;
            else rpm_hold = RPM_W'(RPM_NUMERATOR_T / span);
            index_stamp = t;
         end
         z_seen = z;
      end
      w.position  = enc_count;
      w.speed_rpm = rpm_hold;
      return w;
   endfunction

   // Accepted words feed the model
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && req_bus.valid && req_bus.ready) begin
         w = advance_encoder(opcode_type'(req_bus.opcode), req_bus.a_level,
                             req_bus.b_level, req_bus.z_level, req_bus.time_us);
         pending_rsp.push_back(w);
         words_accepted++;
         if (w.index_event) index_edges++;
         if (req_bus.opcode == OP_LOAD) loads_taken++;
      end
   end

   // Result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            flag_mismatch($sformatf("unexpected word: position %0d rpm %0d index %0b",
                                    rsp_bus.position, rsp_bus.speed_rpm,
                                    rsp_bus.index_event));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.position !== want.position)
               flag_mismatch($sformatf("word %0d position got %0d want %0d",
                                       results_checked, rsp_bus.position, want.position));
            if (rsp_bus.speed_rpm !== want.speed_rpm)
               flag_mismatch($sformatf("word %0d speed_rpm got %0d want %0d",
                                       results_checked, rsp_bus.speed_rpm, want.speed_rpm));
            if (rsp_bus.index_event !== want.index_event)
               flag_mismatch($sformatf("word %0d index_event got %0b want %0b",
                                       results_checked, rsp_bus.index_event,
                                       want.index_event));
         end
         results_checked++;
      end
   end

   // Result receiver with random back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= receiver_stalls ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
      end
   end

   // Send one word; called at a falling edge, returns at a falling edge
   task automatic send_word(input opcode_type op, input logic a, input logic b,
                            input logic z, input logic [TIME_W-1:0] t);
      if (sender_gaps) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.a_level <= a;
      req_bus.b_level <= b;
      req_bus.z_level <= z;
      req_bus.time_us <= t;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type which,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= which;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (which)
         CSR_PLAIN_MODE:      plain_reg  = value[0];
         CSR_PRESET_POSITION: preset_reg = value;
         default: ;
      endcase
   endtask

   // Gray sequence of the A/B pair, returned as {a, b}
   function automatic logic [1:0] gray_levels(input int unsigned g);
      case (g)
         0:       return 2'b00;
         1:       return 2'b10;
         2:       return 2'b11;
         default: return 2'b01;
      endcase
   endfunction

   function automatic int unsigned gray_phase(input logic [1:0] ab);
      case (ab)
         2'b00:   return 0;
         2'b10:   return 1;
         2'b11:   return 2;
         default: return 3;
      endcase
   endfunction

   // Reset values and a load with the default preset; load ignores the pins
   task automatic test_reset_state();
      send_word(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
      send_word(OP_LOAD,   1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
   endtask

   // Forward and reverse steps, then both channels changing at once
   task automatic test_quadrature_steps();
      send_word(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 32'd10);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd20);
      send_word(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd30);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd40);
      send_word(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd50);
   endtask

   // Index periods: zero, just under a minute, a full minute, wrapped time
   task automatic test_index_speed();
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd0);    // A edge and index together
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd100);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd59999999);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd60000000);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd119999999);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd120000000);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'h0000_0005);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'h0000_001F); // period wraps past zero
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'h0000_0040); // Z held, no new edge
   endtask

   // Preset at both ends of the range, then step across the wrap
   task automatic test_preset_wrap();
      drain_results();
      write_register(CSR_PRESET_POSITION, 32'h7FFF_FFFF);
      send_word(OP_LOAD,   1'b0, 1'b0, 1'b0, 32'h0000_0000);
      send_word(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'h0000_0100);
      drain_results();
      write_register(CSR_PRESET_POSITION, 32'h8000_0000);
      send_word(OP_LOAD,   1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'h0000_0200);
   endtask

   // Single-edge counting: only A rise with B low and B rise with A low count
   task automatic test_plain_edges();
      logic [31:0] junk;
      junk = $urandom;
      drain_results();
      write_register(CSR_PLAIN_MODE, {junk[31:1], 1'b1});
      send_word(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd300);
      send_word(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 32'd310);
      send_word(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd320);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd330);
      send_word(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd340);
      send_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd350);
   endtask

   // Random encoder walks with index pulses, plus noise and loads
   task automatic test_random_traffic(input int unsigned total);
      int unsigned per_phase, roll, countdown, pulse_left, g;
      int dir;
      logic [TIME_W-1:0] now_us;
      logic [POS_W-1:0]  preset_pick;
      logic [31:0]       junk;
      logic [1:0]        ab;
      logic              zl;
      per_phase  = total / 6;
      now_us     = $urandom;
      g          = 0;
      dir        = 1;
      countdown  = 10;
      pulse_left = 0;
      for (int p = 0; p < 6; p++) begin
         drain_results();
         case (p)
            0:       preset_pick = 32'h7FFF_FFFF;
            1:       preset_pick = 32'h8000_0000;
            2:       preset_pick = 32'h0000_0000;
            3:       preset_pick = 32'hFFFF_FFFF;
            default: preset_pick = $urandom;
         endcase
         write_register(CSR_PRESET_POSITION, preset_pick);
         junk = $urandom;
         write_register(CSR_PLAIN_MODE, {junk[31:1], p[0]});
         // one phase runs with no gaps on either side
         sender_gaps     = (p != 2);
         receiver_stalls = (p != 2);
         for (int n = 0; n < per_phase; n++) begin
            // timestamp: mostly short steps, some repeats and long jumps
            roll = $urandom_range(0, 99);
            if (roll < 4) now_us += $urandom;
            else if (roll >= 9) now_us += $urandom_range(1, 4000);
            roll = $urandom_range(0, 99);
            junk = $urandom;
            if (roll < 3) begin
               send_word(OP_LOAD, junk[0], junk[1], junk[2], $urandom);
            end else if (roll < 10) begin
               g = gray_phase({junk[0], junk[1]});
               send_word(OP_SAMPLE, junk[0], junk[1], junk[2], now_us);
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 8) dir = -dir;
               if (roll >= 25) g = (g + 4 + dir) % 4;
               if (countdown == 0) begin
                  pulse_left = $urandom_range(1, 3);
                  countdown  = $urandom_range(4, 40);
               end else begin
                  countdown--;
               end
               zl = (pulse_left > 0);
               if (pulse_left > 0) pulse_left--;
               ab = gray_levels(g);
               send_word(OP_SAMPLE, ab[1], ab[0], zl, now_us);
            end
         end
      end
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // Test sequence
   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_PLAIN_MODE;
      csr_wr_data      = '0;
      req_bus.valid    = 1'b0;
      req_bus.opcode   = OP_SAMPLE;
      req_bus.a_level  = 1'b0;
      req_bus.b_level  = 1'b0;
      req_bus.z_level  = 1'b0;
      req_bus.time_us  = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_quadrature_steps();
      test_index_speed();
      test_preset_wrap();
      test_plain_edges();
      test_random_traffic(1800);
      drain_results();

      $display("run covered %0d words (%0d loads, %0d index edges) in both counting modes",
               words_accepted, loads_taken, index_edges);
      $display("%0d results checked, %0d mismatches", results_checked, error_count);
      if (error_count == 0) begin
         $display("quadrature_counter_index_rpm_unit test passed");
      end else begin
         $display("quadrature_counter_index_rpm_unit test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/qcir_pkg.sv
hw/rtl/qcir_ifs.sv
hw/rtl/qcir_ctrl.sv
hw/rtl/qcir_datapath.sv
hw/rtl/qcir_rsp_buf.sv
hw/rtl/quadrature_counter_index_rpm_unit.sv
hw/rtl/qcir_checker.sv
sim/quadrature_counter_index_rpm_unit_tb.sv
